// ===== hdl/cmc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmc_pkg
// shared types, codes and constants of the contact manifold cache
// ----------------------------------------------------------------------------
package cmc_pkg;

    localparam int SLOTS      = 4;
    localparam int IDX_W      = 2;
    localparam int VEC_W      = 48;
    localparam int DEP_W      = 16;
    localparam int FRAC_BITS  = 10;
    localparam int MUL_W      = 25;
    localparam int ACC_W      = 96;
    localparam int COORD_BITS = 16;
    localparam logic [31:0] THR_RESET = 32'd1024;

    // command codes carried in tuser
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_PRUNE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // result status codes
    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_EVICTED = 3'd2;
    localparam logic [2:0] ST_PRUNED  = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    // product shift codes of the multiply-accumulate unit
    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_24 = 2'd1;
    localparam logic [1:0] SH_25 = 2'd2;
    localparam logic [1:0] SH_48 = 2'd3;

    typedef struct packed {
        logic       en;
        logic       clr;
        logic       neg;
        logic [1:0] sh;
    } mac_ctl_t;

    typedef struct packed {
        logic [DEP_W-1:0] dep;
        logic [VEC_W-1:0] n;
        logic [VEC_W-1:0] la;
        logic [VEC_W-1:0] wb;
        logic [VEC_W-1:0] wa;
    } slot_t;

    // the three slots that stay when slot k is left out, j-th of them
    function automatic logic [IDX_W-1:0] tri_idx(input logic [IDX_W-1:0] k,
                                                 input logic [IDX_W-1:0] j);
        tri_idx = (j < k) ? j : IDX_W'(j + 2'd1);
    endfunction

endpackage

// ===== hdl/contact_manifold_cache_top.sv =====
// ----------------------------------------------------------------------------
// contact_manifold_cache_top
// four-slot persistent contact cache with add, prune and clear commands
// ----------------------------------------------------------------------------
// One command item is taken at a time and answers with one result item
// (an unused command gives none). All dot products, cross products and
// squares run through a single 25x25 multiply-accumulate unit, one product
// per cycle, so latency follows the number of held contacts. An add into a
// full cache computes four area scores, where the deepest held slot, when
// there is one, is skipped, and prune ends its work early on a contact that
// is kept by the normal-distance test. A finished result waits in an
// output register while the next command is taken.
module contact_manifold_cache_top
#(
    parameter int COORD_BITS = cmc_pkg::COORD_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // wa[47:0], wb[95:48], la[143:96], normal[191:144], penetration[207:192]
    input  logic [207:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot_written[1:0], slot_evicted[3:2], removed_count[6:4],
    // point_count[9:7], zero fill above
    output logic [15:0]  m_tdata,
    // status[2:0]
    output logic [2:0]   m_tuser,
    input  logic         cfg_wen,
    input  logic [31:0]  cfg_wdata
);

    localparam int MW = cmc_pkg::MUL_W;
    localparam int AW = cmc_pkg::ACC_W;
    localparam int VW = cmc_pkg::VEC_W;
    localparam int XW = cmc_pkg::IDX_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DUP   = 4'd1;
    localparam logic [3:0] S_DEEP  = 4'd2;
    localparam logic [3:0] S_LOAD  = 4'd3;
    localparam logic [3:0] S_AREA  = 4'd4;
    localparam logic [3:0] S_EVICT = 4'd5;
    localparam logic [3:0] S_WRITE = 4'd6;
    localparam logic [3:0] S_PLOAD = 4'd7;
    localparam logic [3:0] S_PRUNE = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    localparam logic signed [AW-1:0] SAT_POS = AW'(64'sd1073741824);
    localparam logic signed [AW-1:0] SAT_NEG = -SAT_POS;

    // signed component c of a packed vector, bits above the word read as zero
    function automatic logic signed [MW-1:0] comp(input logic [VW-1:0] v,
                                                  input logic [1:0] c);
        logic [63:0]         w;
        logic [COORD_BITS-1:0] f;
        w = {16'b0, v} >> (c * COORD_BITS);
        f = w[COORD_BITS-1:0];
        comp = {{(MW-COORD_BITS){f[COORD_BITS-1]}}, f};
    endfunction

    // control and payload registers
    logic [3:0]              state_reg, state_next;
    logic [4:0]              step_reg, step_next;
    logic [XW-1:0]           idx_reg, idx_next;
    logic [1:0]              sub_reg, sub_next;
    logic [2:0]              held_reg, held_next;
    logic [31:0]             thr_reg, thr_next;
    logic [2:0]              status_reg, status_next;
    logic [XW-1:0]           written_reg, written_next;
    logic [XW-1:0]           evicted_reg, evicted_next;
    logic [2:0]              removed_reg, removed_next;
    logic                    deep_hit_reg, deep_hit_next;
    logic [XW-1:0]           deep_idx_reg, deep_idx_next;
    logic signed [AW-1:0]    best_reg, best_next;
    logic [XW-1:0]           best_idx_reg, best_idx_next;
    logic [VW-1:0]           in_wa_reg, in_wb_reg, in_la_reg, in_n_reg;
    logic [15:0]             in_pen_reg;
    logic [VW-1:0]           lv_reg [3];
    logic [VW-1:0]           lv_next [3];
    logic [VW-1:0]           mag_reg [3];
    logic [VW-1:0]           mag_next [3];
    logic [VW-1:0]           dn10_reg, dn10_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [15:0]             out_data_reg, out_data_next;
    logic [2:0]              out_user_reg, out_user_next;
    cmc_pkg::slot_t          slot_reg [cmc_pkg::SLOTS];

    // datapath signals
    cmc_pkg::mac_ctl_t       mac_ctl;
    logic signed [MW-1:0]    op_a, op_b;
    logic signed [AW-1:0]    acc;
    logic signed [AW-1:0]    acc_mag;
    logic signed [AW-1:0]    rsh;
    logic signed [AW-1:0]    thr_ext;
    logic signed [AW-1:0]    p_full;
    logic signed [AW-1:0]    p_sat;
    logic signed [MW-1:0]    nd;
    logic signed [MW-1:0]    av [3];
    logic signed [MW-1:0]    bv [3];
    logic [XW-1:0]           rd_sel;
    cmc_pkg::slot_t          rd;
    logic [XW-1:0]           hm1;
    logic                    use_sq;
    logic [3:0]              sq_q;
    logic [1:0]              sq_c, sq_p;
    logic [1:0]              pc;
    logic [VW-1:0]           sq_m;
    logic signed [15:0]      deep_best;
    logic                    deep_hit;
    logic [XW-1:0]           deep_sel;
    logic                    wr_en;
    logic [XW-1:0]           wr_addr;
    cmc_pkg::slot_t          wr_data;
    cmc_pkg::slot_t          in_slot;

    assign hm1     = XW'(held_reg - 3'd1);
    assign thr_ext = $signed({{(AW-32){1'b0}}, thr_reg});
    assign acc_mag = acc[AW-1] ? -acc : acc;
    assign rsh     = (acc + AW'(512)) >>> cmc_pkg::FRAC_BITS;
    assign in_slot = '{dep: in_pen_reg, n: in_n_reg, la: in_la_reg,
                       wb: in_wb_reg, wa: in_wa_reg};

    // single slot read port
    always_comb
    begin
        case (state_reg)
            S_LOAD:  rd_sel = cmc_pkg::tri_idx(idx_reg, sub_reg);
            S_PRUNE: rd_sel = hm1;
            S_EVICT: rd_sel = XW'(cmc_pkg::SLOTS - 1);
            default: rd_sel = idx_reg;
        endcase
        rd = slot_reg[rd_sel];
    end

    // edge vectors for the area estimate
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            av[c] = comp(in_la_reg, 2'(c)) - comp(lv_reg[0], 2'(c));
            bv[c] = comp(lv_reg[2], 2'(c)) - comp(lv_reg[1], 2'(c));
        end
    end

    // deepest held contact against the new one
    always_comb
    begin
        deep_best = $signed(in_pen_reg);
        deep_hit  = 1'b0;
        deep_sel  = '0;
        for (int i = 0; i < cmc_pkg::SLOTS; i++)
        begin
            if ($signed(slot_reg[i].dep) > deep_best)
            begin
                deep_best = $signed(slot_reg[i].dep);
                deep_hit  = 1'b1;
                deep_sel  = XW'(i);
            end
        end
    end

    // plane difference of one component, rounded and saturated
    always_comb
    begin
        pc     = 2'((step_reg - 5'd6) >> 1);
        nd     = comp(lv_reg[1], pc) - comp(lv_reg[0], pc);
        p_full = {{(AW-MW){nd[MW-1]}}, nd} + rsh;
        if (p_full > SAT_POS)
        begin
            p_sat = SAT_POS;
        end
        else if (p_full < SAT_NEG)
        begin
            p_sat = SAT_NEG;
        end
        else
        begin
            p_sat = p_full;
        end
    end

    // micro-step decode for the shared unit
    always_comb
    begin
        mac_ctl = '0;
        op_a    = '0;
        op_b    = '0;
        use_sq  = 1'b0;
        sq_q    = '0;
        case (state_reg)
            S_DUP:
            begin
                if (step_reg < 5'd3)
                begin
                    mac_ctl.en  = 1'b1;
                    mac_ctl.clr = (step_reg == 5'd0);
                    op_a = comp(rd.wa, step_reg[1:0]) - comp(in_wa_reg, step_reg[1:0]);
                    op_b = op_a;
                end
            end
            S_AREA:
            begin
                mac_ctl.en = (step_reg < 5'd15);
                case (step_reg)
                    5'd0:
                    begin
                        op_a = av[1]; op_b = bv[2]; mac_ctl.clr = 1'b1;
                    end
                    5'd1:
                    begin
                        op_a = av[2]; op_b = bv[1]; mac_ctl.neg = 1'b1;
                    end
                    5'd2:
                    begin
                        op_a = av[2]; op_b = bv[0]; mac_ctl.clr = 1'b1;
                    end
                    5'd3:
                    begin
                        op_a = av[0]; op_b = bv[2]; mac_ctl.neg = 1'b1;
                    end
                    5'd4:
                    begin
                        op_a = av[0]; op_b = bv[1]; mac_ctl.clr = 1'b1;
                    end
                    5'd5:
                    begin
                        op_a = av[1]; op_b = bv[0]; mac_ctl.neg = 1'b1;
                    end
                    default: ;
                endcase
                if (step_reg >= 5'd6 && step_reg <= 5'd14)
                begin
                    use_sq = 1'b1;
                    sq_q   = 4'(step_reg - 5'd6);
                end
            end
            S_PRUNE:
            begin
                if (step_reg < 5'd3)
                begin
                    mac_ctl.en  = 1'b1;
                    mac_ctl.clr = (step_reg == 5'd0);
                    op_a = comp(lv_reg[0], step_reg[1:0]) - comp(lv_reg[1], step_reg[1:0]);
                    op_b = comp(lv_reg[2], step_reg[1:0]);
                end
                else if (step_reg >= 5'd4 && step_reg <= 5'd9)
                begin
                    mac_ctl.en = 1'b1;
                    op_a = comp(lv_reg[2], 2'((step_reg - 5'd4) >> 1));
                    if (!step_reg[0])
                    begin
                        mac_ctl.clr = 1'b1;
                        mac_ctl.sh  = cmc_pkg::SH_24;
                        op_b = {dn10_reg[VW-1], dn10_reg[VW-1:24]};
                    end
                    else
                    begin
                        op_b = {1'b0, dn10_reg[23:0]};
                    end
                end
                else if (step_reg >= 5'd10 && step_reg <= 5'd18)
                begin
                    mac_ctl.en = 1'b1;
                    use_sq = 1'b1;
                    sq_q   = 4'(step_reg - 5'd10);
                end
            end
            default: ;
        endcase

        // square of a stored magnitude as three half-word products
        case (sq_q)
            4'd0:    begin sq_c = 2'd0; sq_p = 2'd0; end
            4'd1:    begin sq_c = 2'd0; sq_p = 2'd1; end
            4'd2:    begin sq_c = 2'd0; sq_p = 2'd2; end
            4'd3:    begin sq_c = 2'd1; sq_p = 2'd0; end
            4'd4:    begin sq_c = 2'd1; sq_p = 2'd1; end
            4'd5:    begin sq_c = 2'd1; sq_p = 2'd2; end
            4'd6:    begin sq_c = 2'd2; sq_p = 2'd0; end
            4'd7:    begin sq_c = 2'd2; sq_p = 2'd1; end
            4'd8:    begin sq_c = 2'd2; sq_p = 2'd2; end
            default: begin sq_c = 2'd0; sq_p = 2'd0; end
        endcase
        sq_m = mag_reg[sq_c];
        if (use_sq)
        begin
            mac_ctl.en  = 1'b1;
            mac_ctl.clr = (sq_q == 4'd0);
            mac_ctl.neg = 1'b0;
            case (sq_p)
                2'd0:
                begin
                    op_a = {1'b0, sq_m[VW-1:24]}; op_b = op_a;
                    mac_ctl.sh = cmc_pkg::SH_48;
                end
                2'd1:
                begin
                    op_a = {1'b0, sq_m[VW-1:24]}; op_b = {1'b0, sq_m[23:0]};
                    mac_ctl.sh = cmc_pkg::SH_25;
                end
                default:
                begin
                    op_a = {1'b0, sq_m[23:0]}; op_b = op_a;
                    mac_ctl.sh = cmc_pkg::SH_0;
                end
            endcase
        end
    end

    cmc_mac u_mac
    (
        .clk  (clk),
        .ctl  (mac_ctl),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        idx_next      = idx_reg;
        sub_next      = sub_reg;
        held_next     = held_reg;
        thr_next      = cfg_wen ? cfg_wdata : thr_reg;
        status_next   = status_reg;
        written_next  = written_reg;
        evicted_next  = evicted_reg;
        removed_next  = removed_reg;
        deep_hit_next = deep_hit_reg;
        deep_idx_next = deep_idx_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        dn10_next     = dn10_reg;
        lv_next       = lv_reg;
        mag_next      = mag_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = rd;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    status_next  = cmc_pkg::ST_ADDED;
                    written_next = '0;
                    evicted_next = '0;
                    removed_next = '0;
                    idx_next     = '0;
                    step_next    = '0;
                    case (s_tuser)
                        cmc_pkg::CMD_ADD:
                        begin
                            state_next = (held_reg == 3'd0) ? S_WRITE : S_DUP;
                        end
                        cmc_pkg::CMD_PRUNE:
                        begin
                            status_next = cmc_pkg::ST_PRUNED;
                            idx_next    = XW'(held_reg - 3'd1);
                            state_next  = (held_reg == 3'd0) ? S_FIN : S_PLOAD;
                        end
                        cmc_pkg::CMD_CLEAR:
                        begin
                            status_next  = cmc_pkg::ST_CLEARED;
                            removed_next = held_reg;
                            held_next    = 3'd0;
                            state_next   = S_FIN;
                        end
                        default: ;
                    endcase
                end
            end
            S_DUP:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd3)
                begin
                    step_next = '0;
                    if (acc <= thr_ext)
                    begin
                        status_next = cmc_pkg::ST_DUP;
                        state_next  = S_FIN;
                    end
                    else if (idx_reg == hm1)
                    begin
                        state_next = (held_reg == 3'(cmc_pkg::SLOTS)) ? S_DEEP : S_WRITE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_DEEP:
            begin
                deep_hit_next = deep_hit;
                deep_idx_next = deep_sel;
                idx_next      = '0;
                sub_next      = '0;
                state_next    = S_LOAD;
            end
            S_LOAD:
            begin
                if (deep_hit_reg && idx_reg == deep_idx_reg)
                begin
                    // deepest held slot scores zero
                    if (idx_reg == '0)
                    begin
                        best_next     = '0;
                        best_idx_next = '0;
                    end
                    if (idx_reg == XW'(cmc_pkg::SLOTS - 1))
                    begin
                        state_next = S_EVICT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    lv_next[sub_reg] = rd.la;
                    sub_next = sub_reg + 2'd1;
                    if (sub_reg == 2'd2)
                    begin
                        sub_next   = '0;
                        step_next  = '0;
                        state_next = S_AREA;
                    end
                end
            end
            S_AREA:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd2 || step_reg == 5'd4 || step_reg == 5'd6)
                begin
                    mag_next[2'((step_reg >> 1) - 5'd1)] = acc_mag[VW-1:0];
                end
                if (step_reg == 5'd15)
                begin
                    step_next = '0;
                    if (idx_reg == '0 || acc > best_reg)
                    begin
                        best_next     = acc;
                        best_idx_next = idx_reg;
                    end
                    if (idx_reg == XW'(cmc_pkg::SLOTS - 1))
                    begin
                        state_next = S_EVICT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            S_EVICT:
            begin
                // last slot moves into the freed one
                wr_en        = (best_idx_reg != XW'(cmc_pkg::SLOTS - 1));
                wr_addr      = best_idx_reg;
                wr_data      = rd;
                held_next    = 3'(cmc_pkg::SLOTS - 1);
                evicted_next = best_idx_reg;
                status_next  = cmc_pkg::ST_EVICTED;
                state_next   = S_WRITE;
            end
            S_WRITE:
            begin
                wr_en        = 1'b1;
                wr_addr      = held_reg[XW-1:0];
                wr_data      = in_slot;
                written_next = held_reg[XW-1:0];
                held_next    = held_reg + 3'd1;
                state_next   = S_FIN;
            end
            S_PLOAD:
            begin
                lv_next[0] = rd.wa;
                lv_next[1] = rd.wb;
                lv_next[2] = rd.n;
                step_next  = '0;
                state_next = S_PRUNE;
            end
            S_PRUNE:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd3)
                begin
                    dn10_next = rsh[VW-1:0];
                    if (acc > thr_ext)
                    begin
                        step_next = 5'd20;
                    end
                end
                if (step_reg == 5'd6 || step_reg == 5'd8 || step_reg == 5'd10)
                begin
                    mag_next[pc] = p_sat[AW-1] ? VW'(-p_sat) : VW'(p_sat);
                end
                if (step_reg == 5'd19)
                begin
                    if (acc > thr_ext)
                    begin
                        wr_en        = (idx_reg != hm1);
                        wr_addr      = idx_reg;
                        wr_data      = rd;
                        held_next    = held_reg - 3'd1;
                        removed_next = removed_reg + 3'd1;
                    end
                    step_next = 5'd20;
                end
                if (step_next == 5'd20)
                begin
                    step_next = '0;
                    if (idx_reg == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = S_PLOAD;
                    end
                end
            end
            S_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_user_next = status_reg;
                    out_data_next = {6'b0, held_reg, removed_reg, evicted_reg, written_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            idx_reg      <= '0;
            sub_reg      <= '0;
            held_reg     <= '0;
            thr_reg      <= cmc_pkg::THR_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            idx_reg      <= idx_next;
            sub_reg      <= sub_next;
            held_reg     <= held_next;
            thr_reg      <= thr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers and slot store
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        written_reg  <= written_next;
        evicted_reg  <= evicted_next;
        removed_reg  <= removed_next;
        deep_hit_reg <= deep_hit_next;
        deep_idx_reg <= deep_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        dn10_reg     <= dn10_next;
        lv_reg       <= lv_next;
        mag_reg      <= mag_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        if (state_reg == S_IDLE && s_tvalid)
        begin
            in_wa_reg  <= s_tdata[47:0];
            in_wb_reg  <= s_tdata[95:48];
            in_la_reg  <= s_tdata[143:96];
            in_n_reg   <= s_tdata[191:144];
            in_pen_reg <= s_tdata[207:192];
        end
        if (wr_en)
        begin
            slot_reg[wr_addr] <= wr_data;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== hdl/cmc_mac.sv =====
// ----------------------------------------------------------------------------
// cmc_mac
// shared signed multiply-accumulate unit with shifted and negated products
// ----------------------------------------------------------------------------
module cmc_mac
(
    input  logic                                 clk,
    input  cmc_pkg::mac_ctl_t                    ctl,
    input  logic signed [cmc_pkg::MUL_W-1:0]     op_a,
    input  logic signed [cmc_pkg::MUL_W-1:0]     op_b,
    output logic signed [cmc_pkg::ACC_W-1:0]     acc
);

    localparam int PW = 2 * cmc_pkg::MUL_W;

    logic signed [PW-1:0]             prod;
    logic signed [cmc_pkg::ACC_W-1:0] ext;
    logic signed [cmc_pkg::ACC_W-1:0] term;
    logic signed [cmc_pkg::ACC_W-1:0] acc_reg;
    logic signed [cmc_pkg::ACC_W-1:0] acc_next;

    // product, aligned and signed
    always_comb
    begin
        prod = op_a * op_b;
        ext  = {{(cmc_pkg::ACC_W-PW){prod[PW-1]}}, prod};
        case (ctl.sh)
            cmc_pkg::SH_0:  term = ext;
            cmc_pkg::SH_24: term = ext <<< 24;
            cmc_pkg::SH_25: term = ext <<< 25;
            cmc_pkg::SH_48: term = ext <<< 48;
            default:        term = ext;
        endcase
        if (ctl.neg)
        begin
            term = -term;
        end
        acc_next = ctl.clr ? term : acc_reg + term;
    end

    // accumulator
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== hdl/cmc_checker.sv =====
// ----------------------------------------------------------------------------
// cmc_checker
// port-level checks of the contact manifold cache results
// ----------------------------------------------------------------------------
module cmc_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [15:0]  m_tdata,
    input logic [2:0]   m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // an eviction always leaves a full cache with the new item in the last slot
    a_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == cmc_pkg::ST_EVICTED |->
            m_tdata[9:7] == 3'd4 && m_tdata[1:0] == 2'd3 && m_tdata[6:4] == 3'd0)
        else $error("bad eviction result");

    // clear empties the cache and a duplicate writes nothing
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == cmc_pkg::ST_CLEARED || m_tuser == cmc_pkg::ST_DUP) |->
            m_tdata[1:0] == 2'd0 && m_tdata[3:2] == 2'd0 &&
            (m_tuser == cmc_pkg::ST_DUP || m_tdata[9:7] == 3'd0))
        else $error("bad clear or duplicate result");

    // the held and removed counts never exceed the slot count and the upper bits stay zero
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[9:7] <= 3'd4 && m_tdata[6:4] <= 3'd4 && m_tdata[15:10] == 6'd0)
        else $error("count out of range");

endmodule

bind contact_manifold_cache_top cmc_checker u_cmc_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the contact manifold cache
// ----------------------------------------------------------------------------
// Drives add, prune, clear and unused command items with random idling on both
// sides, takes each expected result item from a typed table row or from a
// behavioral copy of the cache and compares them field by field. Threshold settings change between phases while idle.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        logic [1:0]  cmd;
        logic [47:0] wa;
        logic [47:0] wb;
        logic [47:0] la;
        logic [47:0] nrm;
        logic [15:0] pen;
    } cmd_item_t;

    typedef struct {
        logic [2:0] status;
        logic [1:0] written;
        logic [1:0] evicted;
        logic [2:0] removed;
        logic [2:0] held;
    } cache_resp_t;

    typedef struct {
        cmd_item_t   item;
        bit          typed;
        cache_resp_t resp;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [207:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_wen;
    logic [31:0]  cfg_wdata;

    // predictor state
    logic [47:0]  p_wa[cmc_pkg::SLOTS];
    logic [47:0]  p_wb[cmc_pkg::SLOTS];
    logic [47:0]  p_la[cmc_pkg::SLOTS];
    logic [47:0]  p_nrm[cmc_pkg::SLOTS];
    logic [15:0]  p_dep[cmc_pkg::SLOTS];
    int           p_held;
    logic [31:0]  p_thr;

    cache_resp_t  resp_q[$];
    int           mismatches;
    int           resp_seen;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_off_cycles;
    int           evict_seen;
    int           prune_hits;

    contact_manifold_cache_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic signed [63:0] comp(logic [47:0] v, int c);
        logic [15:0] r;
        r = v[c*16 +: 16];
        comp = 64'(signed'(r));
    endfunction

    function automatic logic signed [63:0] round_sh(logic signed [63:0] x);
        round_sh = (x + 64'sd512) >>> cmc_pkg::FRAC_BITS;
    endfunction

    // squared cross-product length for the area rule
    function automatic logic [127:0] quad_area(logic [47:0] nl, int p, int q, int r);
        logic signed [63:0] a[3];
        logic signed [63:0] b[3];
        logic signed [63:0] x[3];
        logic [127:0]       s;
        logic [63:0]        m;
        int                 c;
        for (c = 0; c < 3; c++)
        begin
            a[c] = comp(nl, c) - comp(p_la[p], c);
            b[c] = comp(p_la[r], c) - comp(p_la[q], c);
        end
        x[0] = a[1] * b[2] - a[2] * b[1];
        x[1] = a[2] * b[0] - a[0] * b[2];
        x[2] = a[0] * b[1] - a[1] * b[0];
        s = '0;
        for (c = 0; c < 3; c++)
        begin
            m = (x[c] < 0) ? 64'(-x[c]) : 64'(x[c]);
            s = s + 128'(m) * 128'(m);
        end
        quad_area = s;
    endfunction

    task automatic drop_slot(int i);
        int last;
        last = p_held - 1;
        if (i < last)
        begin
            p_wa[i]  = p_wa[last];
            p_wb[i]  = p_wb[last];
            p_la[i]  = p_la[last];
            p_nrm[i] = p_nrm[last];
            p_dep[i] = p_dep[last];
        end
        p_held = last;
    endtask

    // cache behavior for one accepted command item
    task automatic predict_cache(cmd_item_t it, output bit has, output cache_resp_t r);
        bit                 dup;
        int                 i;
        int                 c;
        int                 deep;
        logic signed [63:0] d;
        logic signed [63:0] best;
        logic signed [63:0] dn;
        logic signed [63:0] dn10;
        logic signed [63:0] pv;
        logic signed [63:0] thr_s;
        logic [63:0]        d2;
        logic [127:0]       ar[4];
        int                 tri_tab[4][3];
        tri_tab = '{'{1, 2, 3}, '{0, 2, 3}, '{0, 1, 3}, '{0, 1, 2}};
        thr_s = $signed({32'b0, p_thr});
        r = '{default: '0};
        has = (it.cmd != cmc_pkg::CMD_NONE);
        if (it.cmd == cmc_pkg::CMD_ADD)
        begin
            dup = 0;
            for (i = 0; i < p_held && !dup; i++)
            begin
                d2 = 0;
                for (c = 0; c < 3; c++)
                begin
                    d = comp(p_wa[i], c) - comp(it.wa, c);
                    d2 += 64'(d * d);
                end
                if (d2 <= 64'(p_thr))
                    dup = 1;
            end
            if (dup)
                r.status = cmc_pkg::ST_DUP;
            else
            begin
                if (p_held >= cmc_pkg::SLOTS)
                begin
                    deep = -1;
                    best = 64'(signed'(it.pen));
                    for (i = 0; i < cmc_pkg::SLOTS; i++)
                    begin
                        if (64'(signed'(p_dep[i])) > best)
                        begin
                            best = 64'(signed'(p_dep[i]));
                            deep = i;
                        end
                    end
                    for (i = 0; i < 4; i++)
                        ar[i] = (i == deep) ? '0 :
                                quad_area(it.la, tri_tab[i][0], tri_tab[i][1], tri_tab[i][2]);
                    if (ar[0] < ar[1])
                    begin
                        if (ar[1] < ar[2])
                            r.evicted = (ar[2] < ar[3]) ? 2'd3 : 2'd2;
                        else
                            r.evicted = (ar[1] < ar[3]) ? 2'd3 : 2'd1;
                    end
                    else if (ar[0] < ar[2])
                        r.evicted = (ar[2] < ar[3]) ? 2'd3 : 2'd2;
                    else
                        r.evicted = (ar[0] < ar[3]) ? 2'd3 : 2'd0;
                    drop_slot(r.evicted);
                    r.status = cmc_pkg::ST_EVICTED;
                end
                else
                    r.status = cmc_pkg::ST_ADDED;
                r.written      = 2'(p_held);
                p_wa[p_held]   = it.wa;
                p_wb[p_held]   = it.wb;
                p_la[p_held]   = it.la;
                p_nrm[p_held]  = it.nrm;
                p_dep[p_held]  = it.pen;
                p_held++;
            end
        end
        else if (it.cmd == cmc_pkg::CMD_PRUNE)
        begin
            for (i = p_held - 1; i >= 0; i--)
            begin
                dn = 0;
                for (c = 0; c < 3; c++)
                    dn += (comp(p_wa[i], c) - comp(p_wb[i], c)) * comp(p_nrm[i], c);
                if (dn > thr_s)
                    continue;
                dn10 = round_sh(dn);
                d2 = 0;
                for (c = 0; c < 3; c++)
                begin
                    pv = comp(p_wb[i], c) - comp(p_wa[i], c)
                         + round_sh(comp(p_nrm[i], c) * dn10);
                    if (pv > 64'sd1073741824)
                        pv = 64'sd1073741824;
                    if (pv < -64'sd1073741824)
                        pv = -64'sd1073741824;
                    d2 += 64'(pv * pv);
                end
                if (d2 > 64'(p_thr))
                begin
                    drop_slot(i);
                    r.removed++;
                end
            end
            r.status = cmc_pkg::ST_PRUNED;
        end
        else if (it.cmd == cmc_pkg::CMD_CLEAR)
        begin
            r.removed = 3'(p_held);
            p_held = 0;
            r.status = cmc_pkg::ST_CLEARED;
        end
        r.held = 3'(p_held);
    endtask

    // send one command item and queue what it should produce
    task automatic send_cmd(cmd_item_t it, bit typed, cache_resp_t want);
        bit          has;
        cache_resp_t r;
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {it.pen, it.nrm, it.la, it.wb, it.wa};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_cache(it, has, r);
        if (has)
        begin
            if (typed)
                r = want;
            resp_q.push_back(r);
            if (r.status == cmc_pkg::ST_EVICTED)
                evict_seen++;
            if (r.status == cmc_pkg::ST_PRUNED && r.removed != 0)
                prune_hits++;
        end
    endtask

    // receiver side: random stalls and result checking
    always @(posedge clk)
    begin
        cache_resp_t e;
        if (m_tvalid && m_tready)
        begin
            resp_seen++;
            if (resp_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item status=%0d", m_tuser);
            end
            else
            begin
                e = resp_q.pop_front();
                if (m_tuser != e.status || m_tdata[1:0] != e.written
                    || m_tdata[3:2] != e.evicted || m_tdata[6:4] != e.removed
                    || m_tdata[9:7] != e.held || m_tdata[15:10] != '0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp st=%0d wr=%0d ev=%0d rm=%0d pc=%0d, got st=%0d %h",
                                 e.status, e.written, e.evicted, e.removed, e.held,
                                 m_tuser, m_tdata);
                end
            end
        end
        if (hold_off_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            m_tready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end

    function automatic logic [47:0] near_vec(logic [47:0] base, int spread);
        logic [47:0] v;
        int          c;
        for (c = 0; c < 3; c++)
            v[c*16 +: 16] = base[c*16 +: 16] + 16'($urandom_range(2*spread, 0) - spread);
        return v;
    endfunction

    function automatic cmd_item_t rand_item(int mode);
        cmd_item_t it;
        int        k;
        it.wa  = {$urandom, $urandom};
        it.wb  = {$urandom, $urandom};
        it.la  = {$urandom, $urandom};
        it.nrm = {$urandom, $urandom};
        it.pen = 16'($urandom);
        k = $urandom_range(99, 0);
        if (mode == 1)
        begin
            // contacts on a small patch so duplicates, evictions and prunes all happen
            it.wa  = near_vec(48'h0, 3000);
            it.wb  = near_vec(it.wa, ($urandom_range(1, 0) == 1) ? 40 : 2000);
            it.la  = near_vec(48'h0, 4000);
            it.nrm = {16'($urandom_range(1024, 0) - 0), 16'h0, 16'($urandom_range(2048, 0) - 1024)};
        end
        if (k < 70)
            it.cmd = cmc_pkg::CMD_ADD;
        else if (k < 88)
            it.cmd = cmc_pkg::CMD_PRUNE;
        else if (k < 96)
            it.cmd = cmc_pkg::CMD_CLEAR;
        else
            it.cmd = cmc_pkg::CMD_NONE;
        return it;
    endfunction

    task automatic drain_idle();
        s_tvalid <= 1'b0;
        while (resp_q.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_thr(logic [31:0] v);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        p_thr = v;
    endtask

    // stimulus
    initial
    begin
        dir_row_t    rows[$];
        dir_row_t    row;
        cmd_item_t   it;
        cache_resp_t none_r;
        int          n;
        int          ph;
        int          i;
        logic [31:0] thr_set[6];
        thr_set = '{32'd1024, 32'd0, 32'hFFFF_FFFF, 32'd40000, 32'd300, 32'd4000000};

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = cmc_pkg::CMD_ADD;
        m_tready = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        mismatches = 0;
        resp_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        evict_seen = 0;
        prune_hits = 0;
        p_held = 0;
        p_thr = cmc_pkg::THR_RESET;
        for (i = 0; i < cmc_pkg::SLOTS; i++)
        begin
            p_wa[i] = '0; p_wb[i] = '0; p_la[i] = '0; p_nrm[i] = '0; p_dep[i] = '0;
        end
        none_r = '{default: '0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: typed rows are plain to read off, others use the predictor
        // prune and clear of an empty cache
        rows.push_back('{'{cmc_pkg::CMD_PRUNE, 48'h0, 48'h0, 48'h0, 48'h0, 16'h0}, 1,
                         '{cmc_pkg::ST_PRUNED, 2'd0, 2'd0, 3'd0, 3'd0}});
        rows.push_back('{'{cmc_pkg::CMD_CLEAR, 48'h0, 48'h0, 48'h0, 48'h0, 16'h0}, 1,
                         '{cmc_pkg::ST_CLEARED, 2'd0, 2'd0, 3'd0, 3'd0}});
        // first add goes to slot zero, extremes of every field
        rows.push_back('{'{cmc_pkg::CMD_ADD, 48'hFFFF_FFFF_FFFF, 48'h0, 48'hFFFF_FFFF_FFFF,
                           48'h0000_0000_0400, 16'h7FFF}, 1,
                         '{cmc_pkg::ST_ADDED, 2'd0, 2'd0, 3'd0, 3'd1}});
        // same point again is dropped
        rows.push_back('{'{cmc_pkg::CMD_ADD, 48'hFFFF_FFFF_FFFF, 48'h0, 48'h0, 48'h0,
                           16'h0}, 1,
                         '{cmc_pkg::ST_DUP, 2'd0, 2'd0, 3'd0, 3'd1}});
        rows.push_back('{'{cmc_pkg::CMD_ADD, 48'h7FFF_7FFF_7FFF, 48'hFFFF_FFFF_FFFF,
                           48'h7FFF_7FFF_7FFF, 48'hFC00_0000_0000, 16'h8000}, 1,
                         '{cmc_pkg::ST_ADDED, 2'd1, 2'd0, 3'd0, 3'd2}});
        rows.push_back('{'{cmc_pkg::CMD_ADD, 48'h8000_8000_8000, 48'h8000_8000_8000,
                           48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 16'h0001}, 1,
                         '{cmc_pkg::ST_ADDED, 2'd2, 2'd0, 3'd0, 3'd3}});
        rows.push_back('{'{cmc_pkg::CMD_ADD, 48'h1000_0000_0000, 48'h0, 48'h0100_0000_0000,
                           48'h0, 16'hFFFF}, 1,
                         '{cmc_pkg::ST_ADDED, 2'd3, 2'd0, 3'd0, 3'd4}});
        // full cache: evictions, with new contact deepest and shallowest
        rows.push_back('{'{cmc_pkg::CMD_ADD, 48'h0000_2000_0000, 48'h0, 48'h0000_0100_0000,
                           48'h0, 16'h7FFF}, 0, none_r});
        rows.push_back('{'{cmc_pkg::CMD_ADD, 48'h0000_0000_2000, 48'h0, 48'h0000_0000_0200,
                           48'h0, 16'h8000}, 0, none_r});
        rows.push_back('{'{cmc_pkg::CMD_ADD, 48'h3000_3000_0000, 48'h0, 48'h0, 48'h0,
                           16'h0}, 0, none_r});
        // unused command gives nothing
        rows.push_back('{'{cmc_pkg::CMD_NONE, 48'h1, 48'h2, 48'h3, 48'h4, 16'h5}, 0, none_r});
        rows.push_back('{'{cmc_pkg::CMD_PRUNE, 48'h0, 48'h0, 48'h0, 48'h0, 16'h0}, 0, none_r});
        // contact kept by the normal-distance test, then one far off-plane
        rows.push_back('{'{cmc_pkg::CMD_CLEAR, 48'h0, 48'h0, 48'h0, 48'h0, 16'h0}, 0, none_r});
        rows.push_back('{'{cmc_pkg::CMD_ADD, 48'h0000_0000_0800, 48'h0, 48'h0,
                           48'h0000_0000_0400, 16'h0100}, 0, none_r});
        rows.push_back('{'{cmc_pkg::CMD_ADD, 48'h0000_0400_0000, 48'h0000_0000_0400, 48'h0,
                           48'h0400_0000_0000, 16'h0100}, 0, none_r});
        rows.push_back('{'{cmc_pkg::CMD_ADD, 48'h0000_0000_C000, 48'h0000_0000_C001, 48'h0,
                           48'h0000_0000_0400, 16'h0100}, 0, none_r});
        rows.push_back('{'{cmc_pkg::CMD_PRUNE, 48'h0, 48'h0, 48'h0, 48'h0, 16'h0}, 0, none_r});
        rows.push_back('{'{cmc_pkg::CMD_CLEAR, 48'h0, 48'h0, 48'h0, 48'h0, 16'h0}, 0, none_r});
        foreach (rows[j])
        begin
            row = rows[j];
            send_cmd(row.item, row.typed, row.resp);
        end
        drain_idle();

        // random phases across idling modes and thresholds
        for (ph = 0; ph < 6; ph++)
        begin
            write_thr(thr_set[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            if (ph == 3)
                hold_off_cycles = 600;
            n = 0;
            while (n < 182)
            begin
                it = rand_item(($urandom_range(9, 0) < 8) ? 1 : 0);
                send_cmd(it, 0, none_r);
                if (it.cmd != cmc_pkg::CMD_NONE)
                    n++;
            end
            drain_idle();
        end
        write_thr(cmc_pkg::THR_RESET);

        $display("covered %0d results with %0d full-cache evictions and %0d prunes that removed",
                 resp_seen, evict_seen, prune_hits);
        $display("contacts, six threshold settings, sender and receiver idling and one long stall");
        if (mismatches == 0 && resp_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #30ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
